@@ src/gtbl_pkg.sv @@
// Shared widths, command codes and glyph size tables for the glyph table lookup.
// Depends on nothing; imported by the top level.
`default_nettype none

package gtbl_pkg;

   localparam int CMD_W    = 1;
   localparam int IDX_W    = 12;
   localparam int CP_W     = 21;
   localparam int LVL_W    = 2;
   localparam int CNT_W    = 13;
   localparam int LCNT_W   = 3;
   localparam int OFF_W    = 21;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam int ENTRY_W  = 16;
   localparam int SIZE_W   = 8;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT = 1'b1;

   localparam logic [OFF_W-1:0] HEADER_BYTES = OFF_W'(12);

   typedef logic [SIZE_W-1:0] size_type;

   // bytes of one glyph bitmap at a level (16, 20, 24, 32 pixel cells)
   function automatic size_type glyph_bytes(input logic [LVL_W-1:0] lvl);
      size_type b;
      case (lvl)
         2'd0:    b = SIZE_W'(16 * 2);
         2'd1:    b = SIZE_W'(20 * 3);
         2'd2:    b = SIZE_W'(24 * 3);
         2'd3:    b = SIZE_W'(32 * 4);
         default: b = '0;
      endcase
      return b;
   endfunction

   // bytes per glyph summed over all levels below lvl
   function automatic size_type planes_below(input logic [LVL_W-1:0] lvl);
      size_type b;
      case (lvl)
         2'd0:    b = SIZE_W'(0);
         2'd1:    b = SIZE_W'(16 * 2);
         2'd2:    b = SIZE_W'(16 * 2 + 20 * 3);
         2'd3:    b = SIZE_W'(16 * 2 + 20 * 3 + 24 * 3);
         default: b = '0;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ src/glyph_table_binary_lookup.sv @@
// Lookup: a binary search probes the sorted table (at most 13 probes, the count being clamped
// to 4096). On a hit the CALC state follows, and then DONE loads the result and raises
// rsp_valid; on a miss DONE follows the last probe, or the request, directly. The next
// transaction is accepted the cycle after the result loads, so a result stall holds off
// the next lookup; table writes are accepted while idle. Synchronous active-high reset
// clears the state, the CSR counts and rsp_valid; table contents are undefined until written.
`default_nettype none

module glyph_table_binary_lookup #(
   parameter int TABLE_DEPTH = 4096,
   parameter int LEVELS_MAX  = 4
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [gtbl_pkg::CMD_W-1:0]       req_command,
   input  wire  [gtbl_pkg::IDX_W-1:0]       req_entry_index,
   input  wire  [gtbl_pkg::CP_W-1:0]        req_code_point,
   input  wire  [gtbl_pkg::LVL_W-1:0]       req_level,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_found,
   output logic [gtbl_pkg::IDX_W-1:0]       rsp_glyph_index,
   output logic [gtbl_pkg::OFF_W-1:0]       rsp_byte_offset,
   input  wire                              csr_write_enable,
   input  wire  [gtbl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [gtbl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gtbl_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_CALC   = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    glyph_count_ff;
   logic [LCNT_W-1:0]   level_count_ff;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;       // one past the last candidate
   logic [CNT_W-1:0]    mid_ff, mid_in;
   logic [ENTRY_W-1:0]  key_ff, key_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic                hit_ff, hit_in;
   logic [OFF_W-1:0]    base_ff, planes_ff, within_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic [OFF_W-1:0]    rsp_offset_ff;

   logic                req_accept, do_write, rd_en, out_free;
   logic [AW-1:0]       rd_addr;
   logic [CNT_W-1:0]    n_clamp, probe_lo, probe_hi;
   logic [CNT_W:0]      mid_sum;
   logic                lookup_miss;

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign do_write   = req_accept && (req_command == CMD_WRITE)
                       && (32'(req_entry_index) < TABLE_DEPTH);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign n_clamp = (32'(glyph_count_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                        : glyph_count_ff;

   assign lookup_miss = (n_clamp == '0)
                        || ({1'b0, req_level} >= level_count_ff)
                        || (32'(req_level) >= LEVELS_MAX)
                        || (req_code_point[CP_W-1:ENTRY_W] != '0);

   assign mid_sum = {1'b0, probe_lo} + {1'b0, probe_hi} - (CNT_W+1)'(1);

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      key_in   = key_ff;
      lvl_in   = lvl_ff;
      hit_in   = hit_ff;
      probe_lo = lo_ff;
      probe_hi = hi_ff;
      rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            probe_lo = '0;
            probe_hi = n_clamp;
            if (req_accept && (req_command == CMD_LOOKUP)) begin
               n_in   = n_clamp;
               lo_in  = '0;
               hi_in  = n_clamp;
               key_in = req_code_point[ENTRY_W-1:0];
               lvl_in = req_level;
               hit_in = 1'b0;
               if (lookup_miss) begin
                  state_in = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (rd_data_ff == key_ff) begin
               hit_in   = 1'b1;
               state_in = ST_CALC;
            end else begin
               // narrow the window and issue the next probe at once
               if (rd_data_ff < key_ff) begin
                  probe_lo = mid_ff + CNT_W'(1);
               end else begin
                  probe_hi = mid_ff;
               end
               lo_in = probe_lo;
               hi_in = probe_hi;
               if (probe_lo < probe_hi) begin
                  rd_en = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CALC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      mid_in  = rd_en ? mid_sum[CNT_W:1] : mid_ff;
      rd_addr = AW'(mid_in);
   end

   // table: one write port for write transactions, one registered read port for probes
   always_ff @(posedge clock) begin
      if (do_write) begin
         table_mem[AW'(req_entry_index)] <= req_code_point[ENTRY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   // offset terms: aligned table end, whole lower planes, position within this plane
   always_ff @(posedge clock) begin
      if (state_ff == ST_SEARCH) begin
         base_ff   <= (HEADER_BYTES + OFF_W'({level_count_ff, 2'b00})
                      + OFF_W'({n_ff, 1'b0}) + OFF_W'(3)) & ~OFF_W'(3);
         planes_ff <= OFF_W'(n_ff) * OFF_W'(planes_below(lvl_ff));
         within_ff <= OFF_W'(mid_ff) * OFF_W'(glyph_bytes(lvl_ff));
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
      lvl_ff <= lvl_in;
      hit_ff <= hit_in;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_found_ff  <= hit_ff;
         rsp_index_ff  <= hit_ff ? mid_ff[IDX_W-1:0] : '0;
         rsp_offset_ff <= hit_ff ? (base_ff + planes_ff + within_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         glyph_count_ff <= '0;
         level_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GLYPH_COUNT: glyph_count_ff <= csr_wdata[CNT_W-1:0];
               CSR_LEVEL_COUNT: level_count_ff <= csr_wdata[LCNT_W-1:0];
               default: ;
            endcase
         end
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_glyph_index = rsp_index_ff;
   assign rsp_byte_offset = rsp_offset_ff;

endmodule

`default_nettype wire
